@@ hdl/rfs_pkg.sv @@
// ----------------------------------------------------------------------------
// rfs_pkg
// Shared constants for the ridge feature score unit.
// ----------------------------------------------------------------------------
package rfs_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;

    localparam logic [31:0] HALF_Q   = 32'd32768;
    localparam logic [47:0] FSUM_MAX = {1'b0, {47{1'b1}}};
    localparam logic [47:0] FSUM_MIN = {1'b1, {47{1'b0}}};
    localparam logic [47:0] NSUM_MAX = {48{1'b1}};

    // register indexes
    localparam logic [1:0] REG_MIN_CONTRAST   = 2'd0;
    localparam logic [1:0] REG_INTEGRAL_WIDTH = 2'd1;
    localparam logic [1:0] REG_TABLE_SIZE     = 2'd2;

    // request types
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

endpackage

@@ hdl/ridge_feature_score_unit.sv @@
// ----------------------------------------------------------------------------
// ridge_feature_score_unit
// Accumulates a normalized ridge score over a pixel's scale samples.
// ----------------------------------------------------------------------------
//  channel | signals                         | direction
//  in      | in_valid/in_ready + fields      | request in
//  out     | out_valid/out_ready + fields    | result out
//  cfg     | cfg_valid/cfg_ready, idx, data  | register write
//
// A table load is written as it is accepted. A scale sample holds the input
// through the 64-step divider for the half-window, two reads of the
// single-port table and the sequencing stages; with a zero molecule width
// the division is skipped. A last sample adds a second 64-step division for
// the score, which is skipped with a zero norm. Reset clears the sums and
// sets the registers to their defaults; the table is not cleared. A stalled
// result holds in the output register; the next request is accepted while
// it waits, and blocks only when another result is due.
// ----------------------------------------------------------------------------
module ridge_feature_score_unit
#(
    parameter int TABLE_DEPTH = rfs_pkg::TABLE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic [9:0]  table_index,
    input  logic signed [31:0] table_value,
    input  logic signed [31:0] odd_coeff,
    input  logic signed [31:0] even_coeff,
    input  logic signed [31:0] width_value,
    input  logic signed [31:0] height_value,
    input  logic [30:0] molecule_width,
    input  logic        last_scale,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] feature_value,
    output logic        zero_norm,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import rfs_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [16:0] DEPTH_L = 17'(TABLE_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_DEN, S_DIV1, S_WAIT1, S_POS, S_IDX, S_RD1, S_RD2,
        S_PROD, S_ACC, S_DIV2, S_WAIT2, S_EMIT, S_DIV1X, S_WAITX, S_HOLD
    } state_t;

    state_t state_reg;

    // configuration
    logic [31:0] min_contrast_reg, integral_width_reg;
    logic [10:0] table_size_reg;

    // integral table
    logic [31:0] mem [TABLE_DEPTH];
    logic [AW-1:0] rd_addr;
    logic [31:0] rd_data_reg;

    // captured request
    logic signed [31:0] odd_reg, even_reg, hv_reg, w_reg;
    logic [30:0] m_reg;
    logic        last_reg;
    logic [16:0] n_reg;     // clamped table size

    logic signed [47:0] fsum_reg;
    logic [47:0] nsum_reg;

    logic [63:0] dvd_reg, dvs_reg;
    logic        div_start;
    logic        div_done;
    logic [63:0] div_q;

    logic [16:0] h_reg;     // |h| up to 0.5
    logic [33:0] pos_hi_reg, pos_lo_reg;
    logic [AW-1:0] idx_hi_reg, idx_lo_reg;
    logic signed [31:0] t_hi_reg;
    logic signed [32:0] d_reg;
    logic [32:0] ad_reg;
    logic [64:0] mc_prod_reg;
    logic [64:0] hd_prod_reg;

    logic        out_valid_reg;
    logic [31:0] out_value_reg;
    logic        out_zero_reg;

    rfs_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dvd_reg),
        .divisor  (dvs_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign div_start = (state_reg == S_DIV1) || (state_reg == S_DIV1X);
    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    // table index from a Q16.16 position, clamped to n-1 and depth-1
    function automatic logic [AW-1:0] pos_index(input logic [33:0] p, input logic [16:0] n);
        logic [50:0] prod;
        logic [34:0] idx;
        logic [16:0] nm1;
        begin
            nm1  = n - 17'd1;
            prod = 51'(p) * 51'(nm1);
            idx  = prod[50:16];
            if (idx > 35'(nm1))
                idx = 35'(nm1);
            pos_index = idx[AW-1:0];
        end
    endfunction

    // memory port: write on load, hi entry read in S_RD1, lo entry after
    assign rd_addr = (state_reg == S_RD1) ? idx_hi_reg : idx_lo_reg;
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready && req_type == REQ_LOAD
            && 17'(table_index) < DEPTH_L)
            mem[AW'(table_index)] <= table_value;
        rd_data_reg <= mem[rd_addr];
    end

    // arithmetic helpers for the accumulate step
    logic signed [50:0] term_c;
    logic signed [47:0] term_k;
    logic signed [49:0] fsum_c;
    logic [48:0] nsum_c;
    logic [47:0] hd_c, nt_c;
    logic [32:0] oa_c;
    logic signed [1:0] sgn;
    always_comb
    begin
        sgn = 2'sd0;
        if (hv_reg != 0 && d_reg != 0)
            sgn = ((hv_reg > 0) == (d_reg > 0)) ? 2'sd1 : -2'sd1;
        term_c = 51'(sgn) * 51'(odd_reg) - 51'(even_reg)
               - $signed({3'b0, mc_prod_reg[63:16]});
        // term saturates on its own before it joins the sum
        if (term_c > $signed(51'(FSUM_MAX)))
            term_k = FSUM_MAX;
        else if (term_c < $signed({{3{1'b1}}, FSUM_MIN}))
            term_k = FSUM_MIN;
        else
            term_k = term_c[47:0];
        fsum_c = 50'(fsum_reg) + 50'(term_k);
        if (fsum_c > $signed(50'(FSUM_MAX)))
            fsum_c = 50'(FSUM_MAX);
        else if (fsum_c < $signed({{2{1'b1}}, FSUM_MIN}))
            fsum_c = {{2{1'b1}}, FSUM_MIN};
        oa_c = odd_reg[31] ? 33'(-34'(odd_reg)) : 33'(odd_reg);
        hd_c = hd_prod_reg[63:16];
        nt_c = (48'(oa_c) > hd_c) ? 48'(oa_c) : hd_c;
        nsum_c = 49'(nsum_reg) + 49'(nt_c);
        if (nsum_c > 49'(NSUM_MAX))
            nsum_c = 49'(NSUM_MAX);
    end

    // main sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            min_contrast_reg   <= '0;
            integral_width_reg <= 32'd65536;
            table_size_reg     <= 11'd1024;
            fsum_reg           <= '0;
            nsum_reg           <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_MIN_CONTRAST:   min_contrast_reg   <= cfg_data;
                    REG_INTEGRAL_WIDTH: integral_width_reg <= cfg_data;
                    REG_TABLE_SIZE:     table_size_reg     <= cfg_data[10:0];
                    default: ;
                endcase
            end
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && req_type == REQ_SAMPLE)
                    begin
                        odd_reg  <= odd_coeff;
                        even_reg <= even_coeff;
                        w_reg    <= width_value;
                        hv_reg   <= height_value;
                        m_reg    <= molecule_width;
                        last_reg <= last_scale;
                        if (table_size_reg < 11'd2)
                            n_reg <= 17'd2;
                        else if (17'(table_size_reg) > DEPTH_L)
                            n_reg <= DEPTH_L;
                        else
                            n_reg <= 17'(table_size_reg);
                        state_reg <= S_DEN;
                    end
                end
                S_DEN:
                begin
                    dvd_reg <= 64'(w_reg[31] ? 33'(-34'(w_reg)) : 33'(w_reg))
                             * 64'(integral_width_reg);
                    dvs_reg <= 64'({m_reg, 1'b0}) * 64'(n_reg);
                    if (m_reg == 0)
                    begin
                        h_reg     <= 17'(HALF_Q);
                        state_reg <= S_POS;
                    end
                    else
                        state_reg <= S_DIV1;
                end
                S_DIV1:  state_reg <= S_WAIT1;
                S_WAIT1:
                begin
                    if (div_done)
                    begin
                        h_reg <= (div_q > 64'(HALF_Q)) ? 17'(HALF_Q) : div_q[16:0];
                        state_reg <= S_POS;
                    end
                end
                S_POS:
                begin
                    if (w_reg[31])
                    begin
                        pos_hi_reg <= 34'(HALF_Q) - 34'(h_reg);
                        pos_lo_reg <= 34'(HALF_Q) + 34'(h_reg);
                    end
                    else
                    begin
                        pos_hi_reg <= 34'(HALF_Q) + 34'(h_reg);
                        pos_lo_reg <= 34'(HALF_Q) - 34'(h_reg);
                    end
                    state_reg <= S_IDX;
                end
                S_IDX:
                begin
                    idx_hi_reg <= pos_index(pos_hi_reg, n_reg);
                    idx_lo_reg <= pos_index(pos_lo_reg, n_reg);
                    state_reg  <= S_RD1;
                end
                S_RD1:   state_reg <= S_RD2;   // reads hi entry
                S_RD2:
                begin
                    t_hi_reg  <= rd_data_reg;
                    state_reg <= S_PROD;
                end
                S_PROD:
                begin
                    // lo entry now in read register
                    d_reg  <= 33'(t_hi_reg) - 33'($signed(rd_data_reg));
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    ad_reg <= d_reg[32] ? 33'(-d_reg) : 33'(d_reg);
                    state_reg <= S_DIV2;
                end
                S_DIV2:
                begin
                    mc_prod_reg <= 65'(min_contrast_reg) * 65'(ad_reg);
                    hd_prod_reg <= 65'(hv_reg[31] ? 33'(-34'(hv_reg)) : 33'(hv_reg))
                                 * 65'(ad_reg);
                    state_reg <= S_WAIT2;
                end
                S_WAIT2:
                begin
                    fsum_reg <= fsum_c[47:0];
                    nsum_reg <= nsum_c[47:0];
                    if (last_reg)
                    begin
                        dvd_reg <= {(fsum_c[49] ? 48'd0 : fsum_c[47:0]), 16'd0};
                        dvs_reg <= 64'(nsum_c[47:0]);
                        state_reg <= S_EMIT;
                    end
                    else
                        state_reg <= S_IDLE;
                end
                S_EMIT:
                begin
                    if (dvs_reg == 0 && !out_valid_reg)
                    begin
                        out_value_reg <= '0;
                        out_zero_reg  <= 1'b1;
                        out_valid_reg <= 1'b1;
                        fsum_reg  <= '0;
                        nsum_reg  <= '0;
                        state_reg <= S_IDLE;
                    end
                    else if (dvs_reg != 0)
                        state_reg <= S_DIV1X;
                end
                S_DIV1X: state_reg <= S_WAITX;
                S_WAITX:
                begin
                    if (div_done)
                        state_reg <= S_HOLD;
                end
                S_HOLD:
                begin
                    if (!out_valid_reg)
                    begin
                        out_value_reg <= (div_q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                                 : div_q[31:0];
                        out_zero_reg  <= 1'b0;
                        out_valid_reg <= 1'b1;
                        fsum_reg  <= '0;
                        nsum_reg  <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign feature_value = out_value_reg;
    assign zero_norm     = out_zero_reg;

    // assertions
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("request accepted while busy");
    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && zero_norm) |-> (feature_value == 32'd0))
        else $error("zero norm with nonzero score");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(feature_value)))
        else $error("result dropped under stall");
endmodule

@@ hdl/rfs_divider.sv @@
// ----------------------------------------------------------------------------
// rfs_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rfs_divider
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);
    logic [63:0] quo_reg, quo_next;
    logic [64:0] rem_reg, rem_next;
    logic [63:0] dvs_reg;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] shifted;

    // one shift-subtract step
    always_comb
    begin
        shifted   = {rem_reg[63:0], quo_reg[63]};
        quo_next  = {quo_reg[62:0], 1'b0};
        rem_next  = shifted;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg)
        begin
            if (shifted >= {1'b0, dvs_reg})
            begin
                rem_next    = shifted - {1'b0, dvs_reg};
                quo_next[0] = 1'b1;
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= done_next;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd64;
            end
            else
            begin
                busy_reg <= busy_next;
                cnt_reg  <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

@@ dv/ridge_feature_score_unit_tb.sv @@
// ----------------------------------------------------------------------------
// ridge_feature_score_unit_tb
// Self-checking bench for the ridge score unit. The low part of the integral
// table and its middle and top entries are loaded first, then directed and
// random scale samples run under several register settings. A scoreboard
// recomputes each pixel score and checks the results in order. Sender bursts,
// receiver stalls and a long output hold apply back-pressure.
// ----------------------------------------------------------------------------
module ridge_feature_score_unit_tb;

    import rfs_pkg::*;

    localparam int DEPTH      = 1024;
    localparam int LOAD_COUNT = 256;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_WAIT = 400;

    // index with no register behind it
    localparam logic [1:0] REG_SPARE = 2'd3;
    // entries read when the table size clamps to the full depth
    localparam logic [9:0] MID_ENTRY = 10'd511;
    localparam logic [9:0] TOP_ENTRY = 10'd1023;

    typedef struct packed {
        logic        rtype;
        logic [9:0]  tidx;
        logic [31:0] tval;
        logic [31:0] odd;
        logic [31:0] even;
        logic [31:0] wv;
        logic [31:0] hv;
        logic [30:0] mw;
        logic        last;
    } score_req_t;

    typedef struct packed {
        logic [31:0] value;
        logic        zflag;
    } score_res_t;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of table, sums and registers; queue of scores due
    // ------------------------------------------------------------------------
    class score_board;
        logic [31:0] tbl [DEPTH];
        longint      fsum;
        longint      nsum;
        logic [31:0] min_con;
        logic [31:0] int_width;
        logic [10:0] tsize;
        score_res_t  scores_due [$];
        int          fails;

        function void clear_state();
            fsum      = 0;
            nsum      = 0;
            min_con   = 32'd0;
            int_width = 32'd65536;
            tsize     = 11'd1024;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] data);
            if (idx == REG_MIN_CONTRAST)
                min_con = data;
            else if (idx == REG_INTEGRAL_WIDTH)
                int_width = data;
            else if (idx == REG_TABLE_SIZE)
                tsize = data[10:0];
        endfunction

        function longint mag(longint v);
            return (v < 0) ? -v : v;
        endfunction

        function longint read_tbl(longint pos, longint n);
            longint idx;
            idx = (pos * (n - 1)) >>> 16;
            if (idx > n - 1)
                idx = n - 1;
            if (idx >= DEPTH)
                idx = DEPTH - 1;
            return longint'($signed(tbl[idx]));
        endfunction

        function longint clamp_f(longint v);
            if (v > 64'sd140737488355327)
                return 64'sd140737488355327;
            if (v < -64'sd140737488355328)
                return -64'sd140737488355328;
            return v;
        endfunction

        // note an accepted request and work out any score it completes
        function void note_request(score_req_t r);
            longint n, w, odd, even, hv, h, d, ad, sgn, term, hd, oa, nt, num;
            longint unsigned q, den, mc, rq;
            score_res_t res;
            if (r.rtype == REQ_LOAD)
            begin
                tbl[r.tidx] = r.tval;
                return;
            end
            n = tsize;
            if (n < 2)
                n = 2;
            if (n > DEPTH)
                n = DEPTH;
            odd  = longint'($signed(r.odd));
            even = longint'($signed(r.even));
            w    = longint'($signed(r.wv));
            hv   = longint'($signed(r.hv));
            // half-window, clamped to +-0.5
            if (r.mw == 0)
                h = (w < 0) ? -32768 : 32768;
            else
            begin
                den = longint'(r.mw) * 2 * n;
                q = (longint'(mag(w)) * longint'({32'd0, int_width})) / den;
                if (q > 32768)
                    q = 32768;
                h = (w < 0) ? -longint'(q) : longint'(q);
            end
            d  = read_tbl(32768 + h, n) - read_tbl(32768 - h, n);
            ad = mag(d);
            sgn = 0;
            if (hv != 0 && d != 0)
                sgn = ((hv > 0) == (d > 0)) ? 1 : -1;
            mc = ({32'd0, min_con} * ad) >> 16;
            term = sgn * odd - even - longint'(mc);
            fsum = clamp_f(fsum + clamp_f(term));
            hd = (mag(hv) * ad) >>> 16;
            oa = mag(odd);
            nt = (oa > hd) ? oa : hd;
            nsum = nsum + nt;
            if (nsum > 64'sd281474976710655)
                nsum = 64'sd281474976710655;
            if (!r.last)
                return;
            if (nsum == 0)
            begin
                res.value = 32'd0;
                res.zflag = 1'b1;
            end
            else
            begin
                num = (fsum > 0) ? fsum : 0;
                rq = longint'(num << 16) / longint'(nsum);
                if (rq > 64'hFFFF_FFFF)
                    rq = 64'hFFFF_FFFF;
                res.value = rq[31:0];
                res.zflag = 1'b0;
            end
            scores_due.push_back(res);
            fsum = 0;
            nsum = 0;
        endfunction

        function void check_result(logic [31:0] value, logic zflag);
            score_res_t e;
            if (scores_due.size() == 0)
            begin
                $error("unexpected result: feature_value %h zero_norm %b", value, zflag);
                fails++;
                return;
            end
            e = scores_due.pop_front();
            if (value !== e.value)
            begin
                $error("feature_value: expected %h actual %h", e.value, value);
                fails++;
            end
            if (zflag !== e.zflag)
            begin
                $error("zero_norm: expected %b actual %b", e.zflag, zflag);
                fails++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and DUT
    // ------------------------------------------------------------------------
    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               req_type = 1'b0;
    logic [9:0]         table_index = '0;
    logic signed [31:0] table_value = '0;
    logic signed [31:0] odd_coeff = '0;
    logic signed [31:0] even_coeff = '0;
    logic signed [31:0] width_value = '0;
    logic signed [31:0] height_value = '0;
    logic [30:0]        molecule_width = '0;
    logic               last_scale = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [31:0]        feature_value;
    logic               zero_norm;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;

    score_board sb = new();
    int         hold_req = 0;
    int         rx_mode = 0;
    int         idle_cycles = 0;

    ridge_feature_score_unit dut (.*);

    initial
    begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Receiver: stall pattern plus a long hold on request
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        int hold_cnt;
        if (hold_req > 0)
        begin
            hold_cnt = hold_req;
            hold_req = 0;
            repeat (hold_cnt)
            begin
                out_ready <= 1'b0;
                @(posedge clk);
            end
        end
        case (rx_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 1) == 1);
            default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(feature_value, zero_norm);
    end

    // watchdog on cycles with no accepted request on any channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
            || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------
    task automatic send_req(score_req_t r);
        req_type       <= r.rtype;
        table_index    <= r.tidx;
        table_value    <= r.tval;
        odd_coeff      <= r.odd;
        even_coeff     <= r.even;
        width_value    <= r.wv;
        height_value   <= r.hv;
        molecule_width <= r.mw;
        last_scale     <= r.last;
        in_valid       <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(r);
    endtask

    task automatic pause_in(int cycles);
        in_valid <= 1'b0;
        repeat (cycles)
            @(posedge clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [31:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    // wait until every score has arrived and the pipeline is quiet
    task automatic drain();
        pause_in(1);
        while (sb.scores_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT)
            @(posedge clk);
    endtask

    // random Q16.16 word biased to extremes and modest magnitudes
    function automatic logic [31:0] rnd_q();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3, 4: return $urandom;
            default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        endcase
    endfunction

    function automatic logic [30:0] rnd_mw();
        case ($urandom_range(0, 9))
            0: return 31'd0;
            1: return 31'h7FFF_FFFF;
            2: return 31'($urandom);
            default: return 31'($urandom_range(32'h0000_4000, 32'h0004_0000));
        endcase
    endfunction

    function automatic score_req_t sample(logic last);
        score_req_t r;
        r.rtype = REQ_SAMPLE;
        r.tidx  = 10'($urandom);
        r.tval  = $urandom;
        r.odd   = rnd_q();
        r.even  = rnd_q();
        r.wv    = rnd_q();
        r.hv    = rnd_q();
        r.mw    = rnd_mw();
        r.last  = last;
        return r;
    endfunction

    function automatic score_req_t load(logic [9:0] idx, logic [31:0] val);
        score_req_t r;
        r = sample(1'b0);
        r.rtype = REQ_LOAD;
        r.tidx  = idx;
        r.tval  = val;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        score_req_t r;
        int burst;
        logic [31:0] mc_set [6];
        logic [31:0] iw_set [6];
        logic [10:0] ts_set [6];

        mc_set = '{32'd0, 32'hFFFF_FFFF, 32'h0000_8000, 32'd0, 32'h0002_0000, $urandom};
        iw_set = '{32'd65536, 32'hFFFF_FFFF, 32'd0, 32'h0040_0000, 32'h0001_0000, $urandom};
        ts_set = '{11'd256, 11'd2, 11'd1, 11'd200, 11'd37, 11'($urandom_range(2, 256))};

        sb.clear_state();
        for (int i = 0; i < DEPTH; i++)
            sb.tbl[i] = 32'd0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the entries that any table size used below can reach
        for (int i = 0; i < LOAD_COUNT; i++)
        begin
            case (i % 4)
                0: send_req(load(10'(i), 32'h8000_0000));
                1: send_req(load(10'(i), 32'h7FFF_FFFF));
                default: send_req(load(10'(i), $urandom));
            endcase
        end
        send_req(load(MID_ENTRY, $urandom));
        send_req(load(TOP_ENTRY, 32'h7FFF_FFFF));
        pause_in(1);

        // directed samples
        write_cfg(REG_MIN_CONTRAST, 32'd0);
        write_cfg(REG_INTEGRAL_WIDTH, 32'd65536);
        write_cfg(REG_TABLE_SIZE, 32'(LOAD_COUNT));
        write_cfg(REG_SPARE, 32'hFFFF_FFFF);     // ignored
        // zero norm
        r = sample(1'b1); r.odd = 0; r.hv = 0; send_req(r);
        // zero molecule width, both signs of width
        r = sample(1'b1); r.mw = 0; r.wv = 32'h0001_0000; send_req(r);
        r = sample(1'b1); r.mw = 0; r.wv = 32'hFFFF_0000; send_req(r);
        // negative half-window clamped, then a small positive half-window
        r = sample(1'b1); r.mw = 31'd1; r.wv = 32'h8000_0000; send_req(r);
        r = sample(1'b1); r.mw = 31'h7FFF_FFFF; r.wv = 32'h7FFF_FFFF; send_req(r);
        // extremes accumulated over a long pixel to push the sums toward saturation
        for (int i = 0; i < 8; i++)
        begin
            r = sample(i == 7);
            r.odd = 32'h8000_0000; r.even = 32'h8000_0000;
            r.hv = 32'h8000_0000; r.wv = 32'h7FFF_FFFF; r.mw = 31'd1;
            send_req(r);
        end
        for (int i = 0; i < 6; i++)
        begin
            r = sample(i == 5);
            r.odd = 32'h7FFF_FFFF; r.even = 32'h7FFF_FFFF;
            r.hv = 32'h7FFF_FFFF; r.mw = 31'd1;
            send_req(r);
        end
        r = sample(1'b1); r.odd = 32'h0001_0000; r.even = 32'hFFF0_0000; send_req(r);
        drain();

        // table size above depth acts as depth; only both ends and middle read
        write_cfg(REG_TABLE_SIZE, 32'd2047);
        r = sample(1'b0); r.mw = 0; r.wv = 32'h0002_0000; send_req(r);
        r = sample(1'b0); r.mw = 0; r.wv = 32'hFFFE_0000; send_req(r);
        r = sample(1'b1); r.mw = 31'h0001_0000; r.wv = 32'd0; send_req(r);
        drain();

        // random phases, each under its own register setting
        for (int ph = 0; ph < 6; ph++)
        begin
            write_cfg(REG_MIN_CONTRAST, mc_set[ph]);
            write_cfg(REG_INTEGRAL_WIDTH, iw_set[ph]);
            write_cfg(REG_TABLE_SIZE, {21'd0, ts_set[ph]});
            rx_mode = ph % 3;
            if (ph == 1)
                hold_req = 600;             // long output hold, sender keeps going
            for (int k = 0; k < 64; )
            begin
                burst = $urandom_range(1, 12);
                for (int b = 0; b < burst; b++)
                begin
                    if ($urandom_range(0, 15) == 0)
                        send_req(load(10'($urandom), $urandom));
                    else
                    begin
                        send_req(sample($urandom_range(0, 2) == 0));
                        k++;
                    end
                end
                if ($urandom_range(0, 2) != 0)
                    pause_in($urandom_range(1, 150));
                if (k > 30 && k < 40 && ph == 3)
                begin
                    // sender waits for every score before going on
                    pause_in(1);
                    while (sb.scores_due.size() != 0)
                        @(posedge clk);
                end
            end
            r = sample(1'b1);               // close the open pixel
            send_req(r);
            drain();
        end

        if (sb.fails == 0 && sb.scores_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
